/* rtl/qgks_pkg.sv */
package qgks_pkg;

	localparam int NVAR_DEF = 16;

	localparam logic [1:0] FUNC_LOAD_COEF  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_STATE = 2'd1;
	localparam logic [1:0] FUNC_STEP       = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic       map_sel;
		logic [3:0] poly_index;
		logic [7:0] term_index;
		logic [3:0] var_index;
		logic [3:0] nibble;
	} req_t;

	typedef struct packed {
		logic [3:0] keystream_nibble;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic start;
		logic step;
		logic row_next;
		logic emit;
		logic last;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	// gf(16) product modulo x^4+x+1
	function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
		logic [3:0] acc;
		logic [3:0] x;
		acc = 4'h0;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
		end
		return acc;
	endfunction

endpackage

/* rtl/quad_gf16_keystream_monomial_unit.sv */
// quadratic keystream generator over gf(16), field x^4+x+1
// req channel: req_valid, req_stall, req (func, map_sel, poly_index, term_index,
//   var_index, nibble). func load coefficient or load state nibble gives no item;
//   out of range indexes and unused func codes are ignored
// func step: NVAR keystream items leave on the rsp channel, last flagged on the
//   final one, then the state is replaced with the next-state map
// rsp channel: rsp_valid, rsp_stall, rsp (keystream_nibble, last)
// a step walks all NVAR*(NVAR+1)/2 monomials one per cycle, all 2*NVAR
//   polynomials of both maps multiplied in parallel from per-lane memories
// after a step is accepted req_stall stays high until the state is replaced, so a
//   new request is taken only after the step ends; the first item follows the
//   monomial walk and the drain state
// a stall on rsp holds the output register and pauses the emit sequence;
//   req_stall is high for the whole step
// reset clears the state nibbles to zero and empties the output register;
//   coefficients must be loaded before a step reads them
module quad_gf16_keystream_monomial_unit #(
	parameter int NVAR = qgks_pkg::NVAR_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  qgks_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output qgks_pkg::rsp_t rsp
);

	qgks_pkg::cmd_t  cmd;
	qgks_pkg::stat_t stat;
	logic [$clog2(NVAR*(NVAR+1)/2)-1:0] addr;

	qgks_ctrl #(.NVAR(NVAR)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd),
		.addr      (addr)
	);

	qgks_dp #(.NVAR(NVAR)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.addr      (addr),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* rtl/qgks_ctrl.sv */
module qgks_ctrl #(
	parameter int NVAR = qgks_pkg::NVAR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  qgks_pkg::req_t       req,
	output logic                 req_stall,
	input  qgks_pkg::stat_t      stat,
	output qgks_pkg::cmd_t       cmd,
	output logic [$clog2(NVAR*(NVAR+1)/2)-1:0] addr
);

	localparam int TERMS = NVAR * (NVAR + 1) / 2;
	localparam int AW = $clog2(TERMS);
	localparam int VW = $clog2(NVAR);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RUN    = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_COMMIT = 3'd4;

	logic [2:0]    state_q, state_n;
	logic [AW-1:0] t_q;
	logic [VW-1:0] j_q, l_q, k_q;
	logic          row_end, is_step;

	assign req_stall = (state_q != ST_IDLE);
	assign is_step   = req_valid && (req.func == qgks_pkg::FUNC_STEP);
	assign row_end   = (l_q == VW'(NVAR - 1));
	assign addr      = t_q;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = req_valid;
				if (is_step) begin
					cmd.start = 1'b1;
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				cmd.row_next = row_end;
				if (t_q == AW'(TERMS - 1)) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = (k_q == VW'(NVAR - 1));
					if (cmd.last) begin
						state_n = ST_COMMIT;
					end
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			t_q <= '0;
			j_q <= '0;
			l_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.start) begin
				t_q <= '0;
				j_q <= '0;
				l_q <= '0;
				k_q <= '0;
			end
			if (cmd.step) begin
				t_q <= t_q + AW'(1);
				if (row_end) begin
					j_q <= j_q + VW'(1);
					l_q <= j_q + VW'(1);
				end else begin
					l_q <= l_q + VW'(1);
				end
			end
			if (cmd.emit) begin
				k_q <= k_q + VW'(1);
			end
		end
	end

endmodule

/* rtl/qgks_dp.sv */
module qgks_dp #(
	parameter int NVAR = qgks_pkg::NVAR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qgks_pkg::req_t       req,
	input  qgks_pkg::cmd_t       cmd,
	input  logic [$clog2(NVAR*(NVAR+1)/2)-1:0] addr,
	output qgks_pkg::stat_t      stat,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output qgks_pkg::rsp_t       rsp
);

	localparam int TERMS = NVAR * (NVAR + 1) / 2;
	localparam int AW = $clog2(TERMS);
	localparam int VW = $clog2(NVAR);

	logic [3:0] cur_q  [NVAR];
	logic [3:0] w_q    [NVAR];
	logic [3:0] s_q    [NVAR];
	logic [3:0] pacc_q [NVAR];
	logic [3:0] qacc_q [NVAR];
	logic [3:0] rdp_s1 [NVAR];
	logic [3:0] rdq_s1 [NVAR];
	logic [3:0] xj_q;
	logic [3:0] m_s1;
	logic       v_s1;
	logic       rsp_valid_q;
	qgks_pkg::rsp_t rsp_q;

	logic [AW+7:0] term_ext;
	logic [VW+3:0] var_ext;
	logic [AW-1:0] waddr;
	logic [VW-1:0] vaddr;
	logic          coef_ok, var_ok, coef_we, var_we;

	assign term_ext = {{AW{1'b0}}, req.term_index};
	assign var_ext  = {{VW{1'b0}}, req.var_index};
	assign waddr    = term_ext[AW-1:0];
	assign vaddr    = var_ext[VW-1:0];
	assign coef_ok  = (32'(req.poly_index) < NVAR) && (32'(req.term_index) < TERMS);
	assign var_ok   = (32'(req.var_index) < NVAR);
	assign coef_we  = cmd.load && (req.func == qgks_pkg::FUNC_LOAD_COEF) && coef_ok;
	assign var_we   = cmd.load && (req.func == qgks_pkg::FUNC_LOAD_STATE) && var_ok;

	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// one coefficient memory per output polynomial and map
	for (genvar k = 0; k < NVAR; k++) begin : g_lane
		logic [3:0] mem_p [TERMS];
		logic [3:0] mem_q [TERMS];
		logic       sel;

		assign sel = (32'(req.poly_index) == k);

		always_ff @(posedge clk) begin
			if (coef_we && sel && !req.map_sel) begin
				mem_p[waddr] <= req.nibble;
			end
			if (cmd.step) begin
				rdp_s1[k] <= mem_p[addr];
			end
		end

		always_ff @(posedge clk) begin
			if (coef_we && sel && req.map_sel) begin
				mem_q[waddr] <= req.nibble;
			end
			if (cmd.step) begin
				rdq_s1[k] <= mem_q[addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NVAR; i++) begin
				cur_q[i] <= 4'h0;
			end
			v_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			if (var_we) begin
				cur_q[vaddr] <= req.nibble;
			end
			if (cmd.commit) begin
				for (int i = 0; i < NVAR; i++) begin
					cur_q[i] <= pacc_q[i];
				end
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < NVAR; i++) begin
				w_q[i] <= cur_q[i];
				s_q[i] <= cur_q[i];
				pacc_q[i] <= 4'h0;
				qacc_q[i] <= 4'h0;
			end
			xj_q <= cur_q[0];
		end else begin
			if (cmd.step) begin
				m_s1 <= qgks_pkg::gf16_mul(xj_q, s_q[0]);
				if (cmd.row_next) begin
					// next row starts one variable further on
					for (int i = 0; i < NVAR; i++) begin
						w_q[i] <= (i < NVAR - 1) ? w_q[(i + 1) % NVAR] : 4'h0;
						s_q[i] <= (i < NVAR - 1) ? w_q[(i + 1) % NVAR] : 4'h0;
					end
					xj_q <= w_q[1];
				end else begin
					for (int i = 0; i < NVAR; i++) begin
						s_q[i] <= (i < NVAR - 1) ? s_q[(i + 1) % NVAR] : 4'h0;
					end
				end
			end
			if (v_s1) begin
				for (int i = 0; i < NVAR; i++) begin
					pacc_q[i] <= pacc_q[i] ^ qgks_pkg::gf16_mul(rdp_s1[i], m_s1);
					qacc_q[i] <= qacc_q[i] ^ qgks_pkg::gf16_mul(rdq_s1[i], m_s1);
				end
			end
			if (cmd.emit) begin
				for (int i = 0; i < NVAR; i++) begin
					qacc_q[i] <= (i < NVAR - 1) ? qacc_q[(i + 1) % NVAR] : 4'h0;
				end
			end
		end
		if (cmd.emit) begin
			rsp_q.keystream_nibble <= qacc_q[0];
			rsp_q.last <= cmd.last;
		end
	end

endmodule
